// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle check that stays live during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: reset check");

`endif

// ===== sv/nvca_pkg.sv =====
// ----------------------------------------------------------------------------
// nvca_pkg
// Shared sizes for the nearest value cost accumulator.
// ----------------------------------------------------------------------------
package nvca_pkg;

    // Store depth and derived widths
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int VAL_W  = 32;
    localparam int COST_W = 33;
    localparam int TOT_W  = 64;

endpackage

// ===== sv/nvca_if.sv =====
// ----------------------------------------------------------------------------
// nvca_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface nvca_in_if
    import nvca_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    start_req;

    modport source (output valid, output value, output start_req, input ready);
    modport sink   (input valid, input value, input start_req, output ready);
endinterface

interface nvca_out_if
    import nvca_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COST_W-1:0] cost;
    logic signed [TOT_W-1:0]  total;
    logic                     full_res;

    modport source (output valid, output cost, output total, output full_res, input ready);
    modport sink   (input valid, input cost, input total, input full_res, output ready);
endinterface

// ===== sv/nvca_ram.sv =====
// ----------------------------------------------------------------------------
// nvca_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nvca_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [W-1:0]             i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]             o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/nearest_value_cost_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// nearest_value_cost_accumulator_top
// Sorted-store nearest neighbor distance with a 64-bit running cost total.
// ----------------------------------------------------------------------------
// One item is in flight at a time; i_in.ready is high only while the block is
// idle. An item passes through a binary search for the rank of the new value,
// reads of its successor and predecessor and the choice of the cost, a shift
// of the entries at and above the rank up by one, the write of the value, the
// posting of the result, and idle, where the next item is taken. An equal
// value or a full store skips the shift and the write. The store memory has
// a single read and a single write port, and each probe and each moved entry
// goes through them. A result waits in an output register and the next item
// is taken while it waits; posting stalls until that register is free.
// The store needs no clearing; start_req just zeroes the count and the total.
// ----------------------------------------------------------------------------
module nearest_value_cost_accumulator_top
    import nvca_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    nvca_in_if.sink     i_in,
    nvca_out_if.source  o_out
);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_RSUCC = 4'd3;
    localparam logic [3:0] S_RPRED = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_COST  = 4'd6;
    localparam logic [3:0] S_SHIFT = 4'd7;
    localparam logic [3:0] S_INS   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Control registers
    logic [3:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [TOT_W-1:0]        r_total, n_total;
    logic                    r_out_valid, n_out_valid;

    // Working registers
    logic signed [VAL_W-1:0] r_v, n_v;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi, n_hi;
    logic [CNT_W-1:0]        r_mid, n_mid;
    logic [VAL_W-1:0]        r_succ, n_succ;
    logic [COST_W-1:0]       r_dp, n_dp;
    logic [COST_W-1:0]       r_ds, n_ds;
    logic [COST_W-1:0]       r_cost, n_cost;
    logic                    r_full, n_full;
    logic [CNT_W-1:0]        r_rem, n_rem;
    logic [ADDR_W-1:0]       r_ridx, n_ridx;
    logic                    r_wpend, n_wpend;
    logic [ADDR_W-1:0]       r_waddr, n_waddr;
    logic [COST_W-1:0]       r_out_cost, n_out_cost;
    logic [TOT_W-1:0]        r_out_total, n_out_total;
    logic                    r_out_full, n_out_full;

    // Store memory port signals
    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic [VAL_W-1:0]        ram_wr_data;
    logic [ADDR_W-1:0]       ram_rd_addr;
    logic [VAL_W-1:0]        ram_rd_data;

    logic [CNT_W-1:0]        w_mid;
    logic                    w_have_pred;
    logic                    w_have_succ;
    logic                    w_equal;
    logic                    w_accept;
    logic                    w_out_free;

    nvca_ram #(
        .W     (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Handshake
    assign i_in.ready    = (r_state == S_IDLE);
    assign w_accept      = i_in.valid && (r_state == S_IDLE);
    assign w_out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.cost     = r_out_cost;
    assign o_out.total    = r_out_total;
    assign o_out.full_res = r_out_full;

    // Search midpoint and neighbor flags
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_have_pred = (r_lo != '0);
    assign w_have_succ = (r_lo < r_cnt);
    assign w_equal     = w_have_succ && (r_succ == r_v);

    // Sequencer next-state and datapath
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_v         = r_v;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_succ      = r_succ;
        n_dp        = r_dp;
        n_ds        = r_ds;
        n_cost      = r_cost;
        n_full      = r_full;
        n_rem       = r_rem;
        n_ridx      = r_ridx;
        n_wpend     = r_wpend;
        n_waddr     = r_waddr;
        n_out_cost  = r_out_cost;
        n_out_total = r_out_total;
        n_out_full  = r_out_full;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_waddr;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = r_lo[ADDR_W-1:0];

        // result taken downstream
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_v  = i_in.value;
                    n_lo = '0;
                    if (i_in.start_req) begin
                        n_cnt   = '0;
                        n_total = '0;
                        n_hi    = '0;
                    end else begin
                        n_hi = r_cnt;
                    end
                    n_state = S_SRD;
                end
            end
            // binary search: probe the midpoint
            S_SRD: begin
                if (r_lo < r_hi) begin
                    ram_rd_addr = w_mid[ADDR_W-1:0];
                    n_mid       = w_mid;
                    n_state     = S_SCMP;
                end else begin
                    n_state = S_RSUCC;
                end
            end
            S_SCMP: begin
                if ($signed(ram_rd_data) < r_v) begin
                    n_lo = r_mid + CNT_W'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRD;
            end
            // fetch successor, then predecessor
            S_RSUCC: begin
                ram_rd_addr = r_lo[ADDR_W-1:0];
                n_state     = S_RPRED;
            end
            S_RPRED: begin
                n_succ      = ram_rd_data;
                ram_rd_addr = r_lo[ADDR_W-1:0] - ADDR_W'(1);
                n_state     = S_DIFF;
            end
            S_DIFF: begin
                n_dp    = {r_v[VAL_W-1], r_v} - {ram_rd_data[VAL_W-1], ram_rd_data};
                n_ds    = {r_succ[VAL_W-1], r_succ} - {r_v[VAL_W-1], r_v};
                n_state = S_COST;
            end
            // pick the cost and decide on insertion
            S_COST: begin
                if (r_cnt == '0) begin
                    n_cost = {r_v[VAL_W-1], r_v};
                end else if (w_equal) begin
                    n_cost = '0;
                end else if (w_have_pred && w_have_succ) begin
                    n_cost = (r_dp < r_ds) ? r_dp : r_ds;
                end else if (w_have_pred) begin
                    n_cost = r_dp;
                end else begin
                    n_cost = r_ds;
                end
                n_full = 1'b0;
                if (w_equal) begin
                    n_state = S_FIN;
                end else if (r_cnt >= CAP_CNT) begin
                    n_full  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_rem   = r_cnt - r_lo;
                    n_ridx  = r_cnt[ADDR_W-1:0] - ADDR_W'(1);
                    n_wpend = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            // move entries at and above the rank up by one, top first
            S_SHIFT: begin
                if (r_wpend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_waddr;
                    ram_wr_data = ram_rd_data;
                end
                if (r_rem != '0) begin
                    ram_rd_addr = r_ridx;
                    n_wpend     = 1'b1;
                    n_waddr     = r_ridx + ADDR_W'(1);
                    n_ridx      = r_ridx - ADDR_W'(1);
                    n_rem       = r_rem - CNT_W'(1);
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_INS;
                end
            end
            S_INS: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_lo[ADDR_W-1:0];
                ram_wr_data = r_v;
                n_cnt       = r_cnt + CNT_W'(1);
                n_state     = S_FIN;
            end
            // post the result once the output register is free
            S_FIN: begin
                if (w_out_free) begin
                    n_total     = r_total + {{(TOT_W-COST_W){r_cost[COST_W-1]}}, r_cost};
                    n_out_total = n_total;
                    n_out_cost  = r_cost;
                    n_out_full  = r_full;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_succ      <= n_succ;
        r_dp        <= n_dp;
        r_ds        <= n_ds;
        r_cost      <= n_cost;
        r_full      <= n_full;
        r_rem       <= n_rem;
        r_ridx      <= n_ridx;
        r_wpend     <= n_wpend;
        r_waddr     <= n_waddr;
        r_out_cost  <= n_out_cost;
        r_out_total <= n_out_total;
        r_out_full  <= n_out_full;
    end

endmodule

// ===== sv/nvca_checker.sv =====
// ----------------------------------------------------------------------------
// nvca_checker
// Port-level checks for the nearest value cost accumulator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nvca_checker
    import nvca_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [TOT_W-1:0]  i_out_total,
    input logic [COST_W-1:0] i_out_cost
);

    // an accepted item keeps the block busy for the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // a new result appears only as the block returns to idle
    `ASSERT_SAME(a_result_at_idle, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready)

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                 i_out_valid && $stable(i_out_total) && $stable(i_out_cost))

    // reset empties the output register
    `ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind nearest_value_cost_accumulator_top nvca_checker u_nvca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_total (o_out.total),
    .i_out_cost  (o_out.cost)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest value cost accumulator. Items go in
// through a valid/ready channel, and each one is run through a local sorted
// store model to predict its result. Results are compared field by field, in
// order, as they leave. The run covers a directed start and random sequences
// under four idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import nvca_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int TAIL_CYCLES = 1100;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [TOT_W-1:0]  total;
        logic              full_flag;
    } t_result;

    // Kinds of value streams within one random sequence
    typedef enum int {
        MODE_NARROW,
        MODE_WIDE,
        MODE_MIXED,
        MODE_REPEAT
    } t_val_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nvca_in_if  in_ch();
    nvca_out_if res_ch();

    nearest_value_cost_accumulator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the sorted store, its fill level and the running total
    logic signed [VAL_W-1:0] ordered_vals [CAPACITY];
    int                      held_count = 0;
    logic [TOT_W-1:0]        cost_sum   = '0;

    t_result pending_results [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int err_count     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int full_drops    = 0;
    int zero_hits     = 0;
    int seq_starts    = 0;
    int cycle_count   = 0;

    // Nearest stored neighbor, then insert once; updates the local state
    function automatic t_result predict_nearest(input logic signed [VAL_W-1:0] v,
                                                input logic st);
        t_result r;
        int      lo;
        int      hi;
        int      mid;
        int      i;
        logic    hit;
        longint  gap;
        longint  d_lo;
        longint  d_hi;
        if (st) begin
            held_count = 0;
            cost_sum   = '0;
        end
        lo = 0;
        hi = held_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (ordered_vals[mid] < v) lo = mid + 1;
            else hi = mid;
        end
        hit = 1'b0;
        if (lo < held_count) hit = (ordered_vals[lo] == v);

        if (held_count == 0) begin
            gap = longint'(v);
        end else if (hit) begin
            gap = 0;
        end else begin
            d_lo = 0;
            d_hi = 0;
            if (lo > 0) d_lo = longint'(v) - longint'(ordered_vals[lo-1]);
            if (lo < held_count) d_hi = longint'(ordered_vals[lo]) - longint'(v);
            if (lo > 0 && lo < held_count) gap = (d_lo < d_hi) ? d_lo : d_hi;
            else if (lo > 0) gap = d_lo;
            else gap = d_hi;
        end

        r.full_flag = 1'b0;
        if (!hit) begin
            if (held_count >= CAPACITY) begin
                r.full_flag = 1'b1;
            end else begin
                for (i = held_count; i > lo; i--) ordered_vals[i] = ordered_vals[i-1];
                ordered_vals[lo] = v;
                held_count++;
            end
        end

        cost_sum = cost_sum + TOT_W'(gap);
        r.cost   = gap[COST_W-1:0];
        r.total  = cost_sum;
        return r;
    endfunction

    task automatic flag_error(input string what, input logic [TOT_W-1:0] want_v,
                              input logic [TOT_W-1:0] got_v);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("tb_top: result %0d %s: expected %h, got %h",
                     results_seen, what, want_v, got_v);
    endtask

    // Send one item; valid stays high after acceptance until a later call idles or drains
    task automatic send_item(input logic signed [VAL_W-1:0] v, input logic st);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid     <= 1'b0;
            in_ch.value     <= $urandom;
            in_ch.start_req <= 1'($urandom);
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.value     <= v;
        in_ch.start_req <= st;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_nearest(v, st));
        items_sent++;
        if (st) seq_starts++;
    endtask

    // Stop sending and wait until every predicted result has left
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Empty store after reset, field extremes, one-sided neighbors, ties
    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_item(-32'sd5, 1'b0);            // no start, empty store
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b0);            // widest distance
        send_item(VAL_MAX, 1'b0);            // equal value
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shAAAA_AAAA, 1'b0);
        // hold off until the block has answered everything
        drain_results();
        send_item(32'sd100, 1'b1);
        send_item(32'sd50, 1'b0);            // successor only
        send_item(32'sd200, 1'b0);           // predecessor only
        send_item(32'sd150, 1'b0);           // tie between neighbors
        send_item(32'sd149, 1'b0);
        send_item(32'sd50, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b1);            // new sequence at max
        send_item(VAL_MIN, 1'b0);
    endtask

    // Short sequences with random content; some skip the start bit
    task automatic test_random_sequences(input int idle_pct, input int stall_pct,
                                         input int n_items);
        int                      sent;
        int                      seq_len;
        int                      k;
        logic                    st;
        t_val_mode               mode;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] v;
        logic signed [VAL_W-1:0] pool [4];
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            seq_len = ($urandom_range(9) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
            mode = t_val_mode'($urandom_range(3));
            base = $urandom;
            for (k = 0; k < 4; k++) pool[k] = base + VAL_W'($urandom_range(7));
            for (k = 0; k < seq_len && sent < n_items; k++) begin
                case (mode)
                    MODE_NARROW: begin
                        v = base + VAL_W'($urandom_range(64)) - 32;
                    end
                    MODE_WIDE: begin
                        v = $urandom;
                    end
                    MODE_MIXED: begin
                        if ($urandom_range(7) == 0) begin
                            case ($urandom_range(3))
                                0: v = VAL_MIN;
                                1: v = VAL_MAX;
                                2: v = '0;
                                default: v = '1;
                            endcase
                        end else begin
                            v = base + VAL_W'($urandom_range(65535));
                        end
                    end
                    default: begin
                        v = pool[$urandom_range(3)];
                    end
                endcase
                // first item opens a sequence, except now and then
                if (k == 0) st = ($urandom_range(9) != 0);
                else st = ($urandom_range(49) == 0);
                send_item(v, st);
                sent++;
            end
        end
    endtask

    // Receiver ready, stalled at the current rate
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                flag_error("arrived with nothing pending", '0,
                           TOT_W'({res_ch.cost, res_ch.full_res}));
            end else begin
                want = pending_results.pop_front();
                if (res_ch.cost !== want.cost)
                    flag_error("cost", TOT_W'(want.cost), TOT_W'(res_ch.cost));
                if (res_ch.total !== want.total)
                    flag_error("total", want.total, res_ch.total);
                if (res_ch.full_res !== want.full_flag)
                    flag_error("full_res", TOT_W'(want.full_flag), TOT_W'(res_ch.full_res));
                if (want.full_flag) full_drops++;
                if (want.cost == '0) zero_hits++;
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.value     <= '0;
        in_ch.start_req <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_sequences(0, 0, 140);
        test_random_sequences(68, 0, 140);
        test_random_sequences(0, 68, 140);
        test_random_sequences(24, 24, 130);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            err_count++;
            $display("tb_top: %0d results never arrived", pending_results.size());
        end

        $display("tb_top: %0d items, %0d results, %0d sequences opened",
                 items_sent, results_seen, seq_starts);
        $display("tb_top: %0d zero-distance results, %0d values dropped at full store",
                 zero_hits, full_drops);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches", err_count);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/nvca_pkg.sv
sv/nvca_if.sv
sv/nvca_ram.sv
sv/nearest_value_cost_accumulator_top.sv
sv/nvca_checker.sv
test/tb_top.sv
